// ===== src/dedup_adjacent_segments_defines.svh =====
// Assertion helpers shared by the front, queue and back RTL files.
`ifndef DEDUP_ADJACENT_SEGMENTS_DEFINES_SVH
`define DEDUP_ADJACENT_SEGMENTS_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define DAS_HOLD(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define DAS_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/dedup_pkg.sv =====
`default_nettype none

package dedup_pkg;

	// wide enough for segment lengths up to 127
	localparam int SEG_LEN_W = 7;

	localparam logic [1:0] KIND_INT = 2'd0;
	localparam logic [1:0] KIND_F32 = 2'd1;
	localparam logic [1:0] KIND_F64 = 2'd2;

	typedef struct packed {
		logic                 bank;
		logic [SEG_LEN_W-1:0] len;
		logic [31:0]          end_offset;
		logic [31:0]          kept_count;
		logic                 ovf;
	} seg_desc_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} bank_rel_t;

	function automatic logic elem_eq(logic [1:0] kind, logic [63:0] a, logic [63:0] b);
		logic nan_a32;
		logic nan_b32;
		logic nan_a64;
		logic nan_b64;
		logic r;
		nan_a32 = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		nan_b32 = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		nan_a64 = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
		nan_b64 = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
		case (kind)
			KIND_F32: begin
				r = !(nan_a32 || nan_b32) &&
				    ((((a[31:0] | b[31:0]) & 32'h7FFF_FFFF) == 32'd0) || (a[31:0] == b[31:0]));
			end
			KIND_F64: begin
				r = !(nan_a64 || nan_b64) &&
				    ((((a | b) & 64'h7FFF_FFFF_FFFF_FFFF) == 64'd0) || (a == b));
			end
			default: begin
				r = (a == b);
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/dedup_mem.sv =====
`default_nettype none

module dedup_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [63:0]   wr_data,
	input  wire logic          rd_a_en,
	input  wire logic [AW-1:0] rd_a_addr,
	output logic      [63:0]   rd_a_data,
	input  wire logic          rd_b_en,
	input  wire logic [AW-1:0] rd_b_addr,
	output logic      [63:0]   rd_b_data
);

	logic [63:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_a_en) begin
			rd_a_data <= mem[rd_a_addr];
		end
		if (rd_b_en) begin
			rd_b_data <= mem[rd_b_addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/dedup_front.sv =====
`default_nettype none
`include "dedup_adjacent_segments_defines.svh"

module dedup_front #(
	parameter int MAX_SEG_LEN = 32,
	parameter int AW          = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [63:0]           s_tdata,
	input  wire logic                  s_tlast,
	input  wire logic                  s_tuser,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [63:0]                wr_data,
	output logic                       rd_a_en,
	output logic [AW-1:0]              rd_a_addr,
	input  wire logic [63:0]           rd_a_data,
	output logic                       push_valid,
	input  wire logic                  push_ready,
	output dedup_pkg::seg_desc_t       push_desc,
	input  wire dedup_pkg::bank_rel_t  rel
);

	import dedup_pkg::*;

	localparam int LW = $clog2(MAX_SEG_LEN + 1);

	logic [1:0]    kind_q;
	logic          sel_q;
	logic [LW-1:0] cur_len_q;
	logic [LW-1:0] prev_len_q;
	logic          mism_q;
	logic          ovf_q;
	logic [31:0]   wr_idx_q;
	logic [31:0]   kept_q;
	logic [1:0]    busy_q;

	logic          s1_valid;
	logic          s1_end;
	logic          s1_cmp;
	logic          s1_force;
	logic [63:0]   s1_value;

	logic          new_bank;
	logic          s_acc;
	logic          room;
	logic [AW-1:0] base_new;
	logic [AW-1:0] base_kept;
	logic          neq;
	logic          mism_nx;
	logic          keep;
	logic          end_done;

	assign cfg_ready = 1'b1;
	assign new_bank  = ~sel_q;
	assign s_tready  = !(s1_valid && s1_end) && !busy_q[new_bank];
	assign s_acc     = s_tvalid && s_tready;
	assign room      = cur_len_q < LW'(MAX_SEG_LEN);

	assign base_new  = new_bank ? AW'(MAX_SEG_LEN) : '0;
	assign base_kept = sel_q ? AW'(MAX_SEG_LEN) : '0;

	assign wr_en     = s_acc && !s_tuser && room;
	assign wr_addr   = base_new + AW'(cur_len_q);
	assign wr_data   = s_tdata;
	assign rd_a_en   = wr_en && (cur_len_q < prev_len_q);
	assign rd_a_addr = base_kept + AW'(cur_len_q);

	assign neq      = s1_force || (s1_cmp && !elem_eq(kind_q, rd_a_data, s1_value));
	assign mism_nx  = mism_q || neq;
	assign keep     = ovf_q || (cur_len_q != prev_len_q) || mism_nx;
	assign end_done = s1_valid && s1_end && (!keep || push_ready);

	assign push_valid           = s1_valid && s1_end && keep;
	assign push_desc.bank       = new_bank;
	assign push_desc.len        = SEG_LEN_W'(cur_len_q);
	assign push_desc.end_offset = wr_idx_q + 32'(cur_len_q);
	assign push_desc.kept_count = kept_q + 32'd1;
	assign push_desc.ovf        = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_INT;
		end else if (cfg_valid) begin
			kind_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && !s_tuser) begin
			s1_cmp   <= room && (cur_len_q < prev_len_q);
			s1_force <= room && (cur_len_q >= prev_len_q);
			s1_value <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s1_end   <= 1'b0;
		end else if (s_acc && !s_tuser) begin
			s1_valid <= 1'b1;
			s1_end   <= s_tlast;
		end else if (!(s1_valid && s1_end) || end_done) begin
			s1_valid <= 1'b0;
			s1_end   <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q      <= 1'b0;
			cur_len_q  <= '0;
			prev_len_q <= '0;
			mism_q     <= 1'b0;
			ovf_q      <= 1'b0;
			wr_idx_q   <= '0;
			kept_q     <= '0;
		end else if (s_acc && s_tuser) begin
			cur_len_q  <= '0;
			prev_len_q <= '0;
			mism_q     <= 1'b0;
			ovf_q      <= 1'b0;
		end else begin
			if (s1_valid && !s1_end) begin
				mism_q <= mism_nx;
			end
			if (end_done) begin
				prev_len_q <= cur_len_q;
				cur_len_q  <= '0;
				mism_q     <= 1'b0;
				ovf_q      <= 1'b0;
				if (keep) begin
					sel_q    <= ~sel_q;
					wr_idx_q <= push_desc.end_offset;
					kept_q   <= push_desc.kept_count;
				end
			end
			if (s_acc) begin
				if (room) begin
					cur_len_q <= cur_len_q + LW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			for (int b = 0; b < 2; b++) begin
				if (push_valid && push_ready && (new_bank == 1'(b))) begin
					busy_q[b] <= 1'b1;
				end else if (rel.valid && (rel.bank == 1'(b))) begin
					busy_q[b] <= 1'b0;
				end
			end
		end
	end

	`DAS_IMPLY(a_push_free_bank, push_valid, !busy_q[new_bank], "segment pushed into a busy bank")
	`DAS_IMPLY(a_rel_of_busy, rel.valid, busy_q[rel.bank], "release of a bank not in use")
	`DAS_HOLD(a_len_bound, (cur_len_q <= LW'(MAX_SEG_LEN)) && (prev_len_q <= LW'(MAX_SEG_LEN)), "segment length past buffer depth")

endmodule

`default_nettype wire

// ===== src/dedup_queue.sv =====
`default_nettype none
`include "dedup_adjacent_segments_defines.svh"

module dedup_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push_valid,
	output logic                       push_ready,
	input  wire dedup_pkg::seg_desc_t  push_data,
	output logic                       pop_valid,
	input  wire logic                  pop_ready,
	output dedup_pkg::seg_desc_t       pop_data
);

	import dedup_pkg::*;

	seg_desc_t  ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_data   = ent_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`DAS_HOLD(a_cnt_bound, cnt_q <= 2'd2, "queue count out of range")

endmodule

`default_nettype wire

// ===== src/dedup_back.sv =====
`default_nettype none
`include "dedup_adjacent_segments_defines.svh"

module dedup_back #(
	parameter int MAX_SEG_LEN = 32,
	parameter int AW          = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  pop_valid,
	output logic                       pop_ready,
	input  wire dedup_pkg::seg_desc_t  pop_data,
	output logic                       rd_b_en,
	output logic [AW-1:0]              rd_b_addr,
	input  wire logic [63:0]           rd_b_data,
	output dedup_pkg::bank_rel_t       rel,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [127:0]               m_tdata,
	output logic                       m_tlast,
	output logic                       m_tuser
);

	import dedup_pkg::*;

	logic                 active_q;
	seg_desc_t            desc_q;
	logic [SEG_LEN_W-1:0] k_q;

	logic                 pend_s1;
	logic                 last_s1;
	logic                 ovf_s1;
	logic [31:0]          off_s1;
	logic [31:0]          cnt_s1;

	logic                 advance;
	logic                 issue;
	logic                 last_elem;

	assign advance   = pend_s1 && (!m_tvalid || m_tready);
	assign issue     = active_q && (!pend_s1 || advance);
	assign last_elem = SEG_LEN_W'(k_q + 1'b1) == desc_q.len;
	assign pop_ready = !active_q || (issue && last_elem);

	assign rd_b_en   = issue;
	assign rd_b_addr = (desc_q.bank ? AW'(MAX_SEG_LEN) : AW'(0)) + AW'(k_q);
	assign rel.valid = issue && last_elem;
	assign rel.bank  = desc_q.bank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			k_q      <= '0;
		end else begin
			if (issue) begin
				k_q <= k_q + 1'b1;
			end
			if (pop_valid && pop_ready) begin
				active_q <= 1'b1;
				k_q      <= '0;
			end else if (issue && last_elem) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			desc_q <= pop_data;
		end
		if (issue) begin
			last_s1 <= last_elem;
			ovf_s1  <= desc_q.ovf;
			off_s1  <= desc_q.end_offset;
			cnt_s1  <= desc_q.kept_count;
		end
		if (advance) begin
			m_tdata <= {cnt_s1, off_s1, rd_b_data};
			m_tlast <= last_s1;
			m_tuser <= ovf_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1  <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (issue) begin
				pend_s1 <= 1'b1;
			end else if (advance) begin
				pend_s1 <= 1'b0;
			end
			if (advance) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	`DAS_IMPLY(a_issue_in_range, issue, k_q < desc_q.len, "element read past segment length")

endmodule

`default_nettype wire

// ===== src/dedup_adjacent_segments.sv =====
// channel   dir  handshake            payload
// cfg       in   cfg_valid/cfg_ready  cfg_data = element_kind
// s         in   s_tvalid/s_tready    s_tdata = elem_value, s_tlast = segment_end,
//                                     s_tuser = empty_segment
// m         out  m_tvalid/m_tready    m_tdata = out_value, end_offset, kept_count,
//                                     m_tlast = out_last, m_tuser = overflow
//
// An item that closes a segment holds intake while the registered memory compare settles the keep
// decision and, for a kept segment, until the queue takes its descriptor.
// Barring output stalls, a kept segment leaves one element per cycle via a registered read.
// Intake stalls while the bank it would fill is still being sent out.
// Reset clears control and counters at once; no clearing pass is needed.
// Output stalls reach intake through the bank still being sent out, not the queue.
`default_nettype none

module dedup_adjacent_segments #(
	parameter int MAX_SEG_LEN = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [63:0]  s_tdata,   // [63:0] elem_value
	input  wire logic         s_tlast,
	input  wire logic         s_tuser,   // [0] empty_segment
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,   // [63:0] out_value, [95:64] end_offset, [127:96] kept_count
	output logic              m_tlast,
	output logic              m_tuser    // [0] overflow
);

	import dedup_pkg::*;

	localparam int DEPTH = 2 * MAX_SEG_LEN;
	localparam int AW    = $clog2(DEPTH);

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [63:0]   wr_data;
	logic          rd_a_en;
	logic [AW-1:0] rd_a_addr;
	logic [63:0]   rd_a_data;
	logic          rd_b_en;
	logic [AW-1:0] rd_b_addr;
	logic [63:0]   rd_b_data;

	logic          push_valid;
	logic          push_ready;
	seg_desc_t     push_desc;
	logic          pop_valid;
	logic          pop_ready;
	seg_desc_t     pop_desc;
	bank_rel_t     rel;

	dedup_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_a_en  (rd_a_en),
		.rd_a_addr(rd_a_addr),
		.rd_a_data(rd_a_data),
		.rd_b_en  (rd_b_en),
		.rd_b_addr(rd_b_addr),
		.rd_b_data(rd_b_data)
	);

	dedup_front #(
		.MAX_SEG_LEN(MAX_SEG_LEN),
		.AW         (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_a_en   (rd_a_en),
		.rd_a_addr (rd_a_addr),
		.rd_a_data (rd_a_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_desc (push_desc),
		.rel       (rel)
	);

	dedup_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_desc),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_desc)
	);

	dedup_back #(
		.MAX_SEG_LEN(MAX_SEG_LEN),
		.AW         (AW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_desc),
		.rd_b_en  (rd_b_en),
		.rd_b_addr(rd_b_addr),
		.rd_b_data(rd_b_data),
		.rel      (rel),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dedup_pkg::*;

	localparam int SEG_CAP = 32;
	localparam logic [1:0] KIND_RSVD = 2'd3;
	localparam int SETTLE_CYCLES = 16;
	localparam int IDLE_LIMIT = 1000;
	localparam int PHASE_ITEMS = 28;

	typedef struct {
		logic [63:0] value;
		logic        last;
		logic [31:0] end_offset;
		logic [31:0] kept_count;
		logic        ovf;
	} kept_elem_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [63:0]  s_tdata;
	logic         s_tlast;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic         m_tlast;
	logic         m_tuser;

	// predicted state of the block
	logic [63:0] bank_mem [0:2*SEG_CAP-1];
	logic        kept_bank = 1'b0;
	int unsigned open_len = 0;
	int unsigned prev_len = 0;
	bit          open_diff = 1'b0;
	bit          open_trunc = 1'b0;
	logic [31:0] elems_written = '0;
	logic [31:0] segs_kept = '0;
	logic [1:0]  kind_cfg = KIND_INT;

	kept_elem_t  kept_elems_q [$];
	logic [63:0] prev_sent [$];
	bit          steady = 1'b0;
	int          out_hold = 0;
	int          quiet_cycles = 0;
	int          err_count = 0;

	dedup_adjacent_segments #(
		.MAX_SEG_LEN(SEG_CAP)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit same_elem(input logic [1:0] kind, input logic [63:0] a,
			input logic [63:0] b);
		logic [31:0] a32;
		logic [31:0] b32;
		bit          a_nan;
		bit          b_nan;
		a32 = a[31:0];
		b32 = b[31:0];
		if (kind == KIND_F32) begin
			a_nan = (a32[30:23] == 8'hFF) && (a32[22:0] != 23'd0);
			b_nan = (b32[30:23] == 8'hFF) && (b32[22:0] != 23'd0);
			if (a_nan || b_nan) begin
				return 1'b0;
			end
			return (a32 == b32) || ({a32[30:0], b32[30:0]} == '0);
		end
		if (kind == KIND_F64) begin
			a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
			b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
			if (a_nan || b_nan) begin
				return 1'b0;
			end
			return (a == b) || ({a[62:0], b[62:0]} == '0);
		end
		return a == b;
	endfunction

	task automatic dedup_predict(input logic [63:0] value, input bit seg_end, input bit empty);
		int unsigned kept_base;
		int unsigned new_base;
		kept_elem_t  e;
		kept_base = kept_bank ? SEG_CAP : 0;
		new_base = kept_bank ? 0 : SEG_CAP;
		if (empty) begin
			open_len = 0;
			open_diff = 1'b0;
			open_trunc = 1'b0;
			prev_len = 0;
			return;
		end
		if (open_len < SEG_CAP) begin
			if (open_len >= prev_len) begin
				open_diff = 1'b1;
			end else if (!same_elem(kind_cfg, bank_mem[kept_base + open_len], value)) begin
				open_diff = 1'b1;
			end
			bank_mem[new_base + open_len] = value;
			open_len++;
		end else begin
			open_trunc = 1'b1;
		end
		if (!seg_end) begin
			return;
		end
		if (open_trunc || open_len != prev_len || open_diff) begin
			elems_written = elems_written + open_len;
			segs_kept = segs_kept + 1;
			for (int k = 0; k < open_len; k++) begin
				e.value = bank_mem[new_base + k];
				e.last = (k + 1 == open_len);
				e.end_offset = elems_written;
				e.kept_count = segs_kept;
				e.ovf = open_trunc;
				kept_elems_q.push_back(e);
			end
			kept_bank = !kept_bank;
		end
		prev_len = open_len;
		open_len = 0;
		open_diff = 1'b0;
		open_trunc = 1'b0;
	endtask

	task automatic send_item(input logic [63:0] value, input bit seg_end, input bit empty);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tlast <= seg_end;
		s_tuser <= empty;
		do @(posedge clk); while (!s_tready);
		dedup_predict(value, seg_end, empty);
	endtask

	task automatic send_segment(input logic [63:0] vals [$]);
		foreach (vals[i]) begin
			send_item(vals[i], i == vals.size() - 1, 1'b0);
		end
		prev_sent = vals;
	endtask

	task automatic send_empty();
		send_item({$urandom, $urandom}, 1'($urandom_range(0, 1)), 1'b1);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (kept_elems_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_kind(input logic [1:0] kind);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= kind;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		kind_cfg = kind;
	endtask

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return {$urandom, 32'h8000_0000};
			4: return {$urandom, 32'h7FC0_0000 | 32'($urandom_range(0, 3))};
			5: return 64'h7FF8_0000_0000_0000 | 64'($urandom_range(0, 3));
			6: return 64'h7FF0_0000_0000_0000;
			7: return {$urandom, 32'h7F80_0000};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] nudge(input logic [63:0] v);
		case ($urandom_range(0, 3))
			0: return v ^ 64'h8000_0000_0000_0000;
			1: return v ^ 64'h0000_0000_8000_0000;
			2: return {$urandom, v[31:0]};
			default: return pick_value();
		endcase
	endfunction

	// integer kind straight out of reset: drop, length change, empty breaks
	task automatic test_int_rules();
		logic [63:0] seg [$];
		seg = '{64'd0};
		send_segment(seg);
		send_segment(seg);
		seg = '{'1, 64'd5};
		send_segment(seg);
		send_segment(seg);
		send_empty();
		send_segment(seg);
		send_item(64'd1, 1'b0, 1'b0);
		send_item(64'd2, 1'b0, 1'b0);
		send_empty();
		send_segment(seg);
	endtask

	task automatic test_f32_rules();
		logic [63:0] seg [$];
		write_kind(KIND_F32);
		seg = '{64'd0};
		send_segment(seg);
		seg = '{64'hDEAD_BEEF_8000_0000};
		send_segment(seg);
		seg = '{64'h0000_0000_7FC0_0000};
		send_segment(seg);
		send_segment(seg);
	endtask

	task automatic test_f64_rules();
		logic [63:0] seg [$];
		write_kind(KIND_F64);
		seg = '{64'h8000_0000_0000_0000};
		send_segment(seg);
		seg = '{64'd0};
		send_segment(seg);
		seg = '{64'h7FF8_0000_0000_0001};
		send_segment(seg);
		send_segment(seg);
	endtask

	// unused kind compares raw bits, so -0 and +0 differ
	task automatic test_reserved_kind();
		logic [63:0] seg [$];
		write_kind(KIND_RSVD);
		seg = '{64'h8000_0000_0000_0000};
		send_segment(seg);
		seg = '{64'd0};
		send_segment(seg);
		send_segment(seg);
	endtask

	task automatic test_overflow();
		logic [63:0] seg [$];
		write_kind(KIND_INT);
		repeat ($urandom_range(SEG_CAP + 1, SEG_CAP + 4)) seg.push_back(pick_value());
		send_segment(seg);
		send_segment(seg);
		seg = '{pick_value(), pick_value()};
		send_segment(seg);
	endtask

	task automatic run_random_phase(input logic [1:0] kind, input int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		int unsigned r;
		logic [63:0] seg [$];
		write_kind(kind);
		sent = 0;
		while (sent < n_items) begin
			steady = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			if (r < 6) begin
				send_empty();
				sent++;
			end else if (r < 10) begin
				// open segment cut off by an empty mark
				len = $urandom_range(1, 4);
				repeat (len) send_item(pick_value(), 1'b0, 1'b0);
				send_empty();
				sent += len + 1;
			end else begin
				seg = {};
				if (r < 55 && prev_sent.size() != 0) begin
					foreach (prev_sent[i]) begin
						seg.push_back(($urandom_range(0, 9) == 0) ? nudge(prev_sent[i])
							: prev_sent[i]);
					end
					if ($urandom_range(0, 9) == 0 && seg.size() > 1) begin
						void'(seg.pop_back());
					end else if ($urandom_range(0, 9) == 0) begin
						seg.push_back(pick_value());
					end
				end else begin
					r = $urandom_range(0, 99);
					if (r < 5) begin
						len = $urandom_range(SEG_CAP + 1, SEG_CAP + 5);
					end else if (r < 12) begin
						len = $urandom_range(8, SEG_CAP);
					end else begin
						len = $urandom_range(1, 5);
					end
					repeat (len) seg.push_back(pick_value());
				end
				send_segment(seg);
				sent += seg.size();
			end
		end
		steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		run_random_phase(KIND_INT, PHASE_ITEMS);
		run_random_phase(KIND_F32, PHASE_ITEMS);
		run_random_phase(KIND_F64, PHASE_ITEMS);
		run_random_phase(KIND_RSVD, PHASE_ITEMS);
		run_random_phase(KIND_F32, PHASE_ITEMS);
		run_random_phase(KIND_INT, PHASE_ITEMS);
		run_random_phase(KIND_F64, PHASE_ITEMS);
		run_random_phase(KIND_INT, PHASE_ITEMS);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				out_hold = steady ? 0 : $urandom_range(0, 7);
			end
			if (out_hold > 0) begin
				out_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		kept_elem_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (kept_elems_q.size() == 0) begin
				$display("%0t: unexpected item expected none actual value %h", $time,
					m_tdata[63:0]);
				err_count++;
			end else begin
				want = kept_elems_q.pop_front();
				if (m_tdata[63:0] !== want.value) begin
					$display("%0t: out_value expected %h actual %h", $time, want.value,
						m_tdata[63:0]);
					err_count++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t: out_last expected %b actual %b", $time, want.last, m_tlast);
					err_count++;
				end
				if (m_tdata[95:64] !== want.end_offset) begin
					$display("%0t: end_offset expected %0d actual %0d", $time,
						want.end_offset, m_tdata[95:64]);
					err_count++;
				end
				if (m_tdata[127:96] !== want.kept_count) begin
					$display("%0t: kept_count expected %0d actual %0d", $time,
						want.kept_count, m_tdata[127:96]);
					err_count++;
				end
				if (m_tuser !== want.ovf) begin
					$display("%0t: overflow expected %b actual %b", $time, want.ovf, m_tuser);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
			$display("dedup_adjacent_segments test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < 2 * SEG_CAP; i++) begin
			bank_mem[i] = '0;
		end
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = KIND_INT;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_int_rules();
		test_f32_rules();
		test_f64_rules();
		test_reserved_kind();
		test_overflow();
		test_random_traffic();
		wait_drained();
		if (err_count == 0 && kept_elems_q.size() == 0) begin
			$display("dedup_adjacent_segments test passed");
		end else begin
			$display("dedup_adjacent_segments test failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/dedup_pkg.sv
src/dedup_mem.sv
src/dedup_front.sv
src/dedup_queue.sv
src/dedup_back.sv
src/dedup_adjacent_segments.sv
tb/sv/tb_top.sv
